>>> hw/rtl/alias_table_builder_assert.svh
// ----------------------------------------------------------------------------
// alias_table_builder assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef ALIAS_TABLE_BUILDER_ASSERT_SVH
`define ALIAS_TABLE_BUILDER_ASSERT_SVH

// same-cycle implication
`define ATB_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ATB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/atb_pkg.sv
// ----------------------------------------------------------------------------
// atb_pkg
// Types and constants shared by the alias table builder modules.
// ----------------------------------------------------------------------------
package atb_pkg;

    localparam int DEPTH       = 1024;
    localparam int IDX_BITS    = 10;
    localparam int COUNT_BITS  = 11;
    localparam int WEIGHT_BITS = 32;
    localparam int TOTAL_BITS  = 42;
    localparam int FRAC_BITS   = 16;
    localparam int PROB_BITS   = 17;
    localparam int QCNT_BITS   = 5;

    localparam logic [PROB_BITS-1:0] PROB_ONE = PROB_BITS'(1) << FRAC_BITS;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_READ   = 1'b1;
    localparam logic KIND_BUILD = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ_WAIT,
        ST_SUM_RD,
        ST_SUM_ACC,
        ST_BIG_CHK,
        ST_BIG_LD,
        ST_SM_CHK,
        ST_SM_LD,
        ST_DIV,
        ST_PAIR,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic                  wt_wr;
        logic [IDX_BITS-1:0]   wt_wr_addr;
        logic                  wt_rd;
        logic [IDX_BITS-1:0]   wt_rd_addr;
        logic                  tab_wr;
        logic                  tab_init;
        logic [IDX_BITS-1:0]   tab_wr_addr;
        logic [IDX_BITS-1:0]   alias_val;
        logic                  tab_rd;
        logic [IDX_BITS-1:0]   tab_rd_addr;
        logic                  sum_clr;
        logic                  sum_acc;
        logic                  big_ld;
        logic                  sm_ld;
        logic                  big_update;
        logic                  div_start;
        logic                  out_build;
        logic                  out_read;
        logic                  out_in_range;
        logic [COUNT_BITS-1:0] count;
    } dp_cmd_t;

    typedef struct packed {
        logic big_le_sum;
        logic sm_gt_sum;
        logic new_big_le_sum;
        logic div_busy;
        logic out_busy;
    } dp_stat_t;

endpackage

>>> hw/rtl/atb_ram.sv
// ----------------------------------------------------------------------------
// atb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module atb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hw/rtl/atb_dp.sv
// ----------------------------------------------------------------------------
// atb_dp
// Datapath: weight and table memories, weight sum, scaled big/small weights,
// bit-serial probability divider and the result register.
// ----------------------------------------------------------------------------
module atb_dp
    import atb_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  dp_cmd_t                cmd,
    output dp_stat_t               stat,
    input  logic [WEIGHT_BITS-1:0] weight,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   out_kind,
    output logic [TOTAL_BITS-1:0]  out_total,
    output logic [PROB_BITS-1:0]   out_prob,
    output logic [IDX_BITS-1:0]    out_alias,
    output logic                   out_in_range
);

    logic [WEIGHT_BITS-1:0] wt_q;
    logic [PROB_BITS-1:0]   prob_q;
    logic [IDX_BITS-1:0]    alias_q;
    logic [PROB_BITS-1:0]   prob_wdata;
    logic [IDX_BITS-1:0]    alias_wdata;

    logic [TOTAL_BITS-1:0]  sum_reg;
    logic [TOTAL_BITS-1:0]  big_w_reg;
    logic [TOTAL_BITS-1:0]  sm_w_reg;
    logic [TOTAL_BITS-1:0]  new_big;
    logic [TOTAL_BITS:0]    new_big_wide;
    logic [TOTAL_BITS:0]    product;

    logic [TOTAL_BITS:0]    rem_reg;
    logic [TOTAL_BITS:0]    rem_try;
    logic [PROB_BITS-1:0]   quo_reg;
    logic [QCNT_BITS-1:0]   qcnt_reg;
    logic                   div_busy_reg;
    logic                   first_reg;

    logic                   out_valid_reg;
    logic                   out_kind_reg;
    logic [TOTAL_BITS-1:0]  out_total_reg;
    logic [PROB_BITS-1:0]   out_prob_reg;
    logic [IDX_BITS-1:0]    out_alias_reg;
    logic                   out_rng_reg;

    atb_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(DEPTH)) u_wt_ram (
        .clk     (clk),
        .wr_en   (cmd.wt_wr),
        .wr_addr (cmd.wt_wr_addr),
        .wr_data (weight),
        .rd_en   (cmd.wt_rd),
        .rd_addr (cmd.wt_rd_addr),
        .rd_data (wt_q)
    );

    atb_ram #(.WIDTH(PROB_BITS), .DEPTH(DEPTH)) u_prob_ram (
        .clk     (clk),
        .wr_en   (cmd.tab_wr),
        .wr_addr (cmd.tab_wr_addr),
        .wr_data (prob_wdata),
        .rd_en   (cmd.tab_rd),
        .rd_addr (cmd.tab_rd_addr),
        .rd_data (prob_q)
    );

    atb_ram #(.WIDTH(IDX_BITS), .DEPTH(DEPTH)) u_alias_ram (
        .clk     (clk),
        .wr_en   (cmd.tab_wr),
        .wr_addr (cmd.tab_wr_addr),
        .wr_data (alias_wdata),
        .rd_en   (cmd.tab_rd),
        .rd_addr (cmd.tab_rd_addr),
        .rd_data (alias_q)
    );

    // a zero sum never pairs, the guard only keeps the quotient defined
    assign prob_wdata  = (cmd.tab_init || sum_reg == '0) ? PROB_ONE : quo_reg;
    assign alias_wdata = cmd.tab_init ? '0 : cmd.alias_val;

    assign product      = (TOTAL_BITS+1)'(wt_q) * (TOTAL_BITS+1)'(cmd.count);
    assign new_big_wide = {1'b0, big_w_reg} + {1'b0, sm_w_reg} - {1'b0, sum_reg};
    assign new_big      = new_big_wide[TOTAL_BITS-1:0];
    assign rem_try      = first_reg ? rem_reg : {rem_reg[TOTAL_BITS-1:0], 1'b0};

    assign stat.big_le_sum     = big_w_reg <= sum_reg;
    assign stat.sm_gt_sum      = sm_w_reg > sum_reg;
    assign stat.new_big_le_sum = new_big <= sum_reg;
    assign stat.div_busy       = div_busy_reg;
    assign stat.out_busy       = out_valid_reg && !out_ready;

    always_ff @(posedge clk)
    begin
        if (cmd.sum_clr)
        begin
            sum_reg <= '0;
        end
        else if (cmd.sum_acc)
        begin
            sum_reg <= sum_reg + TOTAL_BITS'(wt_q);
        end
        if (cmd.big_ld)
        begin
            big_w_reg <= product[TOTAL_BITS-1:0];
        end
        else if (cmd.big_update)
        begin
            big_w_reg <= new_big;
        end
        if (cmd.sm_ld)
        begin
            sm_w_reg <= product[TOTAL_BITS-1:0];
        end
        else if (cmd.big_update && stat.new_big_le_sum)
        begin
            sm_w_reg <= new_big;
        end
    end

    // restoring division, one quotient bit per cycle, MSB first
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_busy_reg <= 1'b0;
            qcnt_reg     <= '0;
            first_reg    <= 1'b0;
        end
        else if (cmd.div_start)
        begin
            div_busy_reg <= 1'b1;
            qcnt_reg     <= QCNT_BITS'(PROB_BITS);
            first_reg    <= 1'b1;
        end
        else if (div_busy_reg)
        begin
            first_reg <= 1'b0;
            qcnt_reg  <= qcnt_reg - 1'b1;
            if (qcnt_reg == QCNT_BITS'(1))
            begin
                div_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            rem_reg <= {1'b0, sm_w_reg};
            quo_reg <= '0;
        end
        else if (div_busy_reg)
        begin
            if (rem_try >= {1'b0, sum_reg})
            begin
                rem_reg <= rem_try - {1'b0, sum_reg};
                quo_reg <= {quo_reg[PROB_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_try;
                quo_reg <= {quo_reg[PROB_BITS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_build || cmd.out_read)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_build)
        begin
            out_kind_reg  <= KIND_BUILD;
            out_total_reg <= sum_reg;
            out_prob_reg  <= '0;
            out_alias_reg <= '0;
            out_rng_reg   <= 1'b0;
        end
        else if (cmd.out_read)
        begin
            out_kind_reg  <= KIND_READ;
            out_total_reg <= '0;
            out_prob_reg  <= cmd.out_in_range ? prob_q : '0;
            out_alias_reg <= cmd.out_in_range ? alias_q : '0;
            out_rng_reg   <= cmd.out_in_range;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_kind     = out_kind_reg;
    assign out_total    = out_total_reg;
    assign out_prob     = out_prob_reg;
    assign out_alias    = out_alias_reg;
    assign out_in_range = out_rng_reg;

endmodule

>>> hw/rtl/atb_ctrl.sv
// ----------------------------------------------------------------------------
// atb_ctrl
// Controller: load/read handling, sum sweep and the big/small pairing sweep.
// ----------------------------------------------------------------------------
module atb_ctrl
    import atb_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                in_cmd,
    input  logic                in_last,
    input  logic [IDX_BITS-1:0] in_index,
    output dp_cmd_t             cmd,
    input  dp_stat_t            stat
);

    state_t                state_reg, state_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic                  built_reg, built_next;
    logic [COUNT_BITS-1:0] i_reg, i_next;
    logic [COUNT_BITS-1:0] bcnt_reg, bcnt_next;
    logic [COUNT_BITS-1:0] scnt_reg, scnt_next;
    logic [IDX_BITS-1:0]   fake_idx_reg, fake_idx_next;
    logic                  fake_vld_reg, fake_vld_next;
    logic                  need_big_reg, need_big_next;
    logic                  need_sm_reg, need_sm_next;
    logic                  rng_reg, rng_next;
    logic [COUNT_BITS-1:0] eff_count;
    logic [COUNT_BITS-1:0] big_idx;
    logic [COUNT_BITS-1:0] sm_idx;
    logic                  big_done;
    logic                  sm_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            built_reg    <= 1'b0;
            i_reg        <= '0;
            bcnt_reg     <= '0;
            scnt_reg     <= '0;
            fake_idx_reg <= '0;
            fake_vld_reg <= 1'b0;
            need_big_reg <= 1'b1;
            need_sm_reg  <= 1'b1;
            rng_reg      <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            built_reg    <= built_next;
            i_reg        <= i_next;
            bcnt_reg     <= bcnt_next;
            scnt_reg     <= scnt_next;
            fake_idx_reg <= fake_idx_next;
            fake_vld_reg <= fake_vld_next;
            need_big_reg <= need_big_next;
            need_sm_reg  <= need_sm_next;
            rng_reg      <= rng_next;
        end
    end

    assign eff_count = built_reg ? '0 : count_reg;
    assign big_idx   = bcnt_reg - 1'b1;
    assign sm_idx    = scnt_reg - 1'b1;
    assign big_done  = (bcnt_reg == count_reg) && (need_big_reg || stat.big_le_sum);
    assign sm_done   = (scnt_reg == count_reg) && (need_sm_reg || stat.sm_gt_sum);

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        built_next    = built_reg;
        i_next        = i_reg;
        bcnt_next     = bcnt_reg;
        scnt_next     = scnt_reg;
        fake_idx_next = fake_idx_reg;
        fake_vld_next = fake_vld_reg;
        need_big_next = need_big_reg;
        need_sm_next  = need_sm_reg;
        rng_next      = rng_reg;
        in_ready      = 1'b0;
        cmd           = '0;
        cmd.count     = count_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_cmd == CMD_LOAD)
                    begin
                        built_next = 1'b0;
                        count_next = eff_count;
                        if (eff_count < COUNT_BITS'(DEPTH))
                        begin
                            cmd.wt_wr      = 1'b1;
                            cmd.wt_wr_addr = eff_count[IDX_BITS-1:0];
                            count_next     = eff_count + 1'b1;
                        end
                        if (in_last)
                        begin
                            i_next      = '0;
                            cmd.sum_clr = 1'b1;
                            state_next  = ST_SUM_RD;
                        end
                    end
                    else
                    begin
                        cmd.tab_rd      = 1'b1;
                        cmd.tab_rd_addr = in_index;
                        rng_next        = built_reg && ({1'b0, in_index} < count_reg);
                        state_next      = ST_READ_WAIT;
                    end
                end
            end
            ST_READ_WAIT:
            begin
                if (!stat.out_busy)
                begin
                    cmd.out_read     = 1'b1;
                    cmd.out_in_range = rng_reg;
                    state_next       = ST_IDLE;
                end
            end
            ST_SUM_RD:
            begin
                // fetch weight and preset the entry to probability one, alias 0
                cmd.wt_rd       = 1'b1;
                cmd.wt_rd_addr  = i_reg[IDX_BITS-1:0];
                cmd.tab_wr      = 1'b1;
                cmd.tab_init    = 1'b1;
                cmd.tab_wr_addr = i_reg[IDX_BITS-1:0];
                i_next          = i_reg + 1'b1;
                state_next      = ST_SUM_ACC;
            end
            ST_SUM_ACC:
            begin
                cmd.sum_acc = 1'b1;
                if (i_reg == count_reg)
                begin
                    bcnt_next     = '0;
                    scnt_next     = '0;
                    fake_vld_next = 1'b0;
                    need_big_next = 1'b1;
                    need_sm_next  = 1'b1;
                    state_next    = ST_BIG_CHK;
                end
                else
                begin
                    state_next = ST_SUM_RD;
                end
            end
            ST_BIG_CHK:
            begin
                if ((need_big_reg || stat.big_le_sum) && bcnt_reg < count_reg)
                begin
                    cmd.wt_rd      = 1'b1;
                    cmd.wt_rd_addr = bcnt_reg[IDX_BITS-1:0];
                    bcnt_next      = bcnt_reg + 1'b1;
                    need_big_next  = 1'b0;
                    state_next     = ST_BIG_LD;
                end
                else
                begin
                    state_next = ST_SM_CHK;
                end
            end
            ST_BIG_LD:
            begin
                cmd.big_ld = 1'b1;
                state_next = ST_BIG_CHK;
            end
            ST_SM_CHK:
            begin
                if ((need_sm_reg || stat.sm_gt_sum) && !fake_vld_reg &&
                    scnt_reg < count_reg)
                begin
                    cmd.wt_rd      = 1'b1;
                    cmd.wt_rd_addr = scnt_reg[IDX_BITS-1:0];
                    scnt_next      = scnt_reg + 1'b1;
                    need_sm_next   = 1'b0;
                    state_next     = ST_SM_LD;
                end
                else if (big_done || sm_done)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_SM_LD:
            begin
                cmd.sm_ld  = 1'b1;
                state_next = ST_SM_CHK;
            end
            ST_DIV:
            begin
                if (!stat.div_busy)
                begin
                    state_next = ST_PAIR;
                end
            end
            ST_PAIR:
            begin
                cmd.tab_wr      = 1'b1;
                cmd.tab_wr_addr = fake_vld_reg ? fake_idx_reg : sm_idx[IDX_BITS-1:0];
                cmd.alias_val   = big_idx[IDX_BITS-1:0];
                cmd.big_update  = 1'b1;
                if (stat.new_big_le_sum)
                begin
                    // large entry drops to the mean: carry it as the next small
                    fake_idx_next = big_idx[IDX_BITS-1:0];
                    fake_vld_next = 1'b1;
                    need_big_next = 1'b1;
                end
                else
                begin
                    fake_vld_next = 1'b0;
                    need_sm_next  = 1'b1;
                end
                state_next = ST_BIG_CHK;
            end
            ST_FINISH:
            begin
                if (!stat.out_busy)
                begin
                    cmd.out_build = 1'b1;
                    built_next    = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> hw/rtl/alias_table_builder.sv
// ----------------------------------------------------------------------------
// alias_table_builder
// Builds a Walker/Vose alias table from loaded integer weights.
// ----------------------------------------------------------------------------
// Load weights one per transfer (tuser 0); the transfer with tlast starts the
// build. A load after a finished build starts a new table; loads past 1024
// entries drop their weight. Loads are accepted back to back. The build holds
// s_tready low through the sum sweep (one weight memory read and one table
// preset per entry) and the pairing sweep, in which the big and small walkers
// fetch weights and each pair waits on the 17-step bit-serial probability
// divider. One build result (tuser 0) carries the weight sum. A read (tuser 1)
// waits on the table memory read and returns the Q1.16 probability and the
// alias of the entry; an index at or beyond the loaded count, or a read before
// any build, returns in_range 0 with zero probability and alias. The result
// register lets a new transfer be accepted while a result waits on m_tready.
// ----------------------------------------------------------------------------
module alias_table_builder
    import atb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // weight[31:0], index[41:32], zero pad
    input  logic        s_tlast,   // is_last
    input  logic        s_tuser,   // cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // total_weight[41:0], probability[58:42],
                                   // alias_res[68:59], in_range[69], zero pad
    output logic        m_tuser    // kind
);

    `include "alias_table_builder_assert.svh"

    dp_cmd_t                cmd;
    dp_stat_t               stat;
    logic [TOTAL_BITS-1:0]  out_total;
    logic [PROB_BITS-1:0]   out_prob;
    logic [IDX_BITS-1:0]    out_alias;
    logic                   out_in_range;

    atb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_cmd   (s_tuser),
        .in_last  (s_tlast),
        .in_index (s_tdata[41:32]),
        .cmd      (cmd),
        .stat     (stat)
    );

    atb_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .weight       (s_tdata[31:0]),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_kind     (m_tuser),
        .out_total    (out_total),
        .out_prob     (out_prob),
        .out_alias    (out_alias),
        .out_in_range (out_in_range)
    );

    assign m_tdata = {2'b00, out_in_range, out_alias, out_prob, out_total};

    // a final load always hands over to the build sweep
    `ATB_ASSERT_NEXT(a_build_blocks, s_tvalid && s_tready && s_tuser == CMD_LOAD && s_tlast, !s_tready, "input still open after final load")
    // a read waits for the table memory before the next transfer
    `ATB_ASSERT_NEXT(a_read_blocks, s_tvalid && s_tready && s_tuser == CMD_READ, !s_tready, "input still open after read")
    // build results carry only the sum
    `ATB_ASSERT_NOW(a_build_fields, m_tvalid && m_tuser == KIND_BUILD, m_tdata[71:42] == '0, "build result has table fields set")
    // out-of-range reads carry zero entry fields
    `ATB_ASSERT_NOW(a_read_range, m_tvalid && m_tuser == KIND_READ && !m_tdata[69], m_tdata[68:0] == '0, "out-of-range read has nonzero fields")

endmodule
